>>> hdl/assert_macros.svh
// Assertion macros used by xor_linked_list_engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> hdl/xlle_pkg.sv
//------------------------------------------------------------------------------
// xlle_pkg
// Shared types and constants of the XOR linked list engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package xlle_pkg;
    localparam int POOL_NODES_DEF = 64;
    localparam int WORD_BITS_DEF  = 32;
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_READ   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_PAST_END = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  position;
    } cmd_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [1:0]        status;
        logic [LEN_W-1:0]  length;
    } rsp_item_t;
endpackage
`default_nettype wire

>>> hdl/xlle_cmd_if.sv
//------------------------------------------------------------------------------
// xlle_cmd_if
// Command channel: valid, ready and the command payload.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface xlle_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] data_in;
    logic [5:0]  position;
    modport source (output valid, cmd, data_in, position, input ready);
    modport sink (input valid, cmd, data_in, position, output ready);
endinterface
`default_nettype wire

>>> hdl/xlle_rsp_if.sv
//------------------------------------------------------------------------------
// xlle_rsp_if
// Response channel: valid, ready and the result payload.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface xlle_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [6:0]  length;
    modport source (output valid, data_out, status, length, input ready);
    modport sink (input valid, data_out, status, length, output ready);
endinterface
`default_nettype wire

>>> hdl/xor_linked_list_engine.sv
// Append scans for a free slot, allocates it and links it behind the tail; read walks
// the links to the position (S_WALK_RD, S_WALK per node); delete walks, then re-links.
// Empty, past-end and unused commands answer straight from idle. One command is in the
// sequencer at a time; the next starts in the cycle after its response transaction,
// and a two-entry queue in front keeps accepting while it has room.
// Reset (rst_n, asynchronous, active low) empties the list and frees every slot.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
//------------------------------------------------------------------------------
// xor_linked_list_engine
// XOR linked list over a fixed slot pool: append, read and delete at position.
//------------------------------------------------------------------------------
module xor_linked_list_engine #(
    parameter int POOL_NODES = xlle_pkg::POOL_NODES_DEF,
    parameter int WORD_BITS  = xlle_pkg::WORD_BITS_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    xlle_cmd_if.sink    cmd_ch,
    xlle_rsp_if.source  rsp_ch
);
    import xlle_pkg::*;

    logic      push, q_full, q_pop, q_not_empty;
    cmd_item_t push_item, q_item;
    logic [$clog2(POOL_NODES+1)-1:0] count;
    logic      full_rsp, pool_full;

    xlle_front u_front (
        .cmd_ch    (cmd_ch),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    xlle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_not_empty)
    );

    xlle_back #(
        .POOL_NODES (POOL_NODES),
        .WORD_BITS  (WORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .rsp_ch      (rsp_ch),
        .count       (count)
    );

    assign full_rsp  = rsp_ch.valid && (rsp_ch.status == ST_FULL);
    assign pool_full = (32'(count) == POOL_NODES);

    `ASSERT_NEVER(a_count_range, clk, rst_n, 32'(count) > POOL_NODES, "count exceeds pool")
    `ASSERT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && !q_not_empty, "pop from empty queue")
    `ASSERT_IMPL(a_full_status, clk, rst_n, full_rsp |-> pool_full, "full status with free slots")
endmodule
`default_nettype wire

>>> hdl/xlle_queue.sv
//------------------------------------------------------------------------------
// xlle_queue
// Two-entry command queue between the front end and the list sequencer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xlle_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire xlle_pkg::cmd_item_t  push_item,
    output logic                      full,
    input  wire logic                 pop,
    output xlle_pkg::cmd_item_t       pop_item,
    output logic                      not_empty
);
    import xlle_pkg::*;

    cmd_item_t  mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_item  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> hdl/xlle_front.sv
//------------------------------------------------------------------------------
// xlle_front
// Accepts command transactions and folds unused codes into a no-op.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xlle_front (
    xlle_cmd_if.sink                 cmd_ch,
    input  wire logic                q_full,
    output logic                     push,
    output xlle_pkg::cmd_item_t      push_item
);
    import xlle_pkg::*;

    assign cmd_ch.ready = ~q_full;
    assign push         = cmd_ch.valid & ~q_full;

    always_comb
    begin
        push_item.data     = cmd_ch.data_in;
        push_item.position = cmd_ch.position;
        case (cmd_ch.cmd)
            CMD_APPEND, CMD_READ, CMD_DELETE: push_item.cmd = cmd_ch.cmd;
            default:                          push_item.cmd = CMD_NONE;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/xlle_back.sv
//------------------------------------------------------------------------------
// xlle_back
// List sequencer: slot allocation, link walk, re-linking and response register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xlle_back #(
    parameter int POOL_NODES = xlle_pkg::POOL_NODES_DEF,
    parameter int WORD_BITS  = xlle_pkg::WORD_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_not_empty,
    input  wire xlle_pkg::cmd_item_t q_item,
    output logic                     q_pop,
    xlle_rsp_if.source               rsp_ch,
    output logic [$clog2(POOL_NODES+1)-1:0] count
);
    import xlle_pkg::*;

    localparam int SW = $clog2(POOL_NODES + 1);
    localparam int IW = $clog2(POOL_NODES);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_ALLOC, S_LINK_TAIL, S_WALK_RD, S_WALK,
        S_DEL_RD, S_DEL_NXT, S_DEL_PRV, S_RESP
    } state_t;

    state_t              state_reg;
    cmd_item_t           item_reg;
    logic [WORD_BITS-1:0] data_mem [POOL_NODES];
    logic [SW-1:0]       link_mem [POOL_NODES];
    logic [POOL_NODES-1:0] used_reg;
    logic [SW-1:0]       head_reg, tail_reg, count_reg;
    logic [SW-1:0]       prev_reg, cur_reg, scan_reg;
    logic [SW-1:0]       step_reg;
    logic [SW-1:0]       link_rd_reg;
    logic [WORD_BITS-1:0] data_rd_reg;
    logic [SW-1:0]       nxt_reg;
    logic [DATA_W-1:0]   dout_reg;
    logic [1:0]          status_reg;
    logic                rsp_valid_reg;
    logic [SW-1:0]       pos_ext;

    assign pos_ext = SW'(item_reg.position);
    assign count   = count_reg;
    assign q_pop   = (state_reg == S_IDLE) && q_not_empty;
    assign rsp_ch.valid    = rsp_valid_reg;
    assign rsp_ch.data_out = dout_reg;
    assign rsp_ch.status   = status_reg;
    assign rsp_ch.length   = LEN_W'(count_reg);

    function automatic logic [IW-1:0] idx(input logic [SW-1:0] s);
        return IW'(s - SW'(1));
    endfunction

    function automatic logic [DATA_W-1:0] to_out(input logic [WORD_BITS-1:0] w);
        logic [63:0] t;
        t = 64'(w);
        return t[DATA_W-1:0];
    endfunction

    // Memory ports: one synchronous read and one write per cycle each.
    logic                 link_we;
    logic [SW-1:0]        link_wa, link_wd, link_ra;
    logic                 data_we;
    logic [WORD_BITS-1:0] data_wd;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[idx(link_wa)] <= link_wd;
        end
        link_rd_reg <= link_mem[idx(link_ra)];
        if (data_we)
        begin
            data_mem[idx(scan_reg)] <= data_wd;
        end
        data_rd_reg <= data_mem[idx(cur_reg)];
    end

    always_comb
    begin
        link_we = 1'b0;
        link_wa = scan_reg;
        link_wd = tail_reg;
        link_ra = cur_reg;
        data_we = 1'b0;
        data_wd = WORD_BITS'(item_reg.data);
        case (state_reg)
            S_ALLOC:
            begin
                link_we = 1'b1;
                data_we = 1'b1;
                link_ra = tail_reg;
            end
            S_LINK_TAIL:
            begin
                link_we = (tail_reg != '0);
                link_wa = tail_reg;
                link_wd = link_rd_reg ^ scan_reg;
            end
            S_DEL_NXT:
            begin
                link_we = (prev_reg != '0);
                link_wa = prev_reg;
                link_wd = link_rd_reg ^ cur_reg ^ nxt_reg;
                link_ra = nxt_reg;
            end
            S_DEL_PRV:
            begin
                link_we = (nxt_reg != '0);
                link_wa = nxt_reg;
                link_wd = link_rd_reg ^ cur_reg ^ prev_reg;
            end
            S_DEL_RD:
            begin
                link_ra = prev_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            dout_reg      <= '0;
            prev_reg      <= '0;
            cur_reg       <= SW'(1);
            scan_reg      <= SW'(1);
            step_reg      <= '0;
            nxt_reg       <= '0;
            item_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        item_reg   <= q_item;
                        dout_reg   <= '0;
                        status_reg <= ST_OK;
                        scan_reg   <= SW'(1);
                        prev_reg   <= '0;
                        cur_reg    <= (head_reg == '0) ? SW'(1) : head_reg;
                        step_reg   <= '0;
                        case (q_item.cmd)
                            CMD_APPEND: state_reg <= S_SCAN;
                            CMD_READ, CMD_DELETE:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_RESP;
                                    rsp_valid_reg <= 1'b1;
                                end
                                else if (SW'(q_item.position) >= count_reg
                                         || 32'(q_item.position) >= POOL_NODES)
                                begin
                                    status_reg <= ST_PAST_END;
                                    state_reg  <= S_RESP;
                                    rsp_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_WALK_RD;
                                end
                            end
                            default:
                            begin
                                state_reg     <= S_RESP;
                                rsp_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                // Lowest free slot: one slot checked per cycle.
                S_SCAN:
                begin
                    if (!used_reg[idx(scan_reg)])
                    begin
                        state_reg <= S_ALLOC;
                    end
                    else if (scan_reg == SW'(POOL_NODES))
                    begin
                        status_reg    <= ST_FULL;
                        state_reg     <= S_RESP;
                        rsp_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + SW'(1);
                    end
                end
                S_ALLOC:
                begin
                    used_reg[idx(scan_reg)] <= 1'b1;
                    if (head_reg == '0)
                    begin
                        head_reg <= scan_reg;
                    end
                    state_reg <= S_LINK_TAIL;
                end
                S_LINK_TAIL:
                begin
                    tail_reg      <= scan_reg;
                    count_reg     <= count_reg + SW'(1);
                    state_reg     <= S_RESP;
                    rsp_valid_reg <= 1'b1;
                end
                // The link and data of cur are read this cycle.
                S_WALK_RD:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (step_reg == pos_ext)
                    begin
                        nxt_reg  <= link_rd_reg ^ prev_reg;
                        dout_reg <= to_out(data_rd_reg);
                        if (item_reg.cmd == CMD_DELETE)
                        begin
                            state_reg <= S_DEL_RD;
                        end
                        else
                        begin
                            state_reg     <= S_RESP;
                            rsp_valid_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= link_rd_reg ^ prev_reg;
                        step_reg  <= step_reg + SW'(1);
                        state_reg <= S_WALK_RD;
                    end
                end
                S_DEL_RD:
                begin
                    state_reg <= S_DEL_NXT;
                end
                S_DEL_NXT:
                begin
                    state_reg <= S_DEL_PRV;
                end
                S_DEL_PRV:
                begin
                    used_reg[idx(cur_reg)] <= 1'b0;
                    if (head_reg == cur_reg)
                    begin
                        head_reg <= nxt_reg;
                    end
                    if (tail_reg == cur_reg)
                    begin
                        tail_reg <= prev_reg;
                    end
                    count_reg     <= count_reg - SW'(1);
                    state_reg     <= S_RESP;
                    rsp_valid_reg <= 1'b1;
                end
                S_RESP:
                begin
                    if (rsp_ch.ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
